// ===== rtl/jsu_pkg.sv =====
// Package for the JSON string unescaper: state, result and error codes,
// the result entry type and the character helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_MISSING_QUOTE = 3'd0,
    ERR_UNTERM_ESCAPE = 3'd1,
    ERR_UNSUPPORTED   = 3'd2,
    ERR_BAD_UNICODE   = 3'd3,
    ERR_UNTERM_STRING = 3'd4
  } err_e;

  // One result entry as it sits in the output queue.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    err_e       err;
    logic       last;
  } result_t;

  localparam int unsigned MaxResults = 3;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = $clog2(QDepth);
  localparam int unsigned QCntW      = $clog2(QDepth + 1);

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerU    = 8'h75;

  // Bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/json_string_unescape.sv =====
// JSON string unescaper: decodes string literals byte by byte, with \u
// escapes expanded to UTF-8. Depends on jsu_pkg.
// Results of an accepted byte are registered into a four-entry output queue,
// behind any queued ones. Throughput: one input byte per cycle unless stalled;
// results leave one per cycle unless out_stall_i is high. A three-byte UTF-8
// burst holds in_stall_o high until the queue drains back to at most one entry.
// Reset (asynchronous, rst_ni low): idle awaiting an opening quote, queue empty.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  wire  [7:0]       in_byte_i,
  input  wire              at_end_i,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [7:0]       out_byte_o,
  output logic [2:0]       error_code_o,
  output logic             last_o
);
  import jsu_pkg::*;

  mode_e       mode_q, mode_d;
  logic [1:0]  hex_count_q, hex_count_d;
  logic [15:0] code_value_q, code_value_d;

  result_t     queue_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  result_t     res [MaxResults];
  logic [1:0]  n_res;
  logic [4:0]  hex_d;
  logic [15:0] code_nxt;
  logic        in_acc, out_acc;

  // Enough room is kept for the largest burst one transaction can cause.
  assign in_stall_o  = (cnt_q > QCntW'(QDepth - MaxResults));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_acc     = out_valid_o && !out_stall_i;

  assign hex_d    = hex_value(in_byte_i);
  assign code_nxt = {code_value_q[11:0], hex_d[3:0]};

  always_comb begin
    mode_d       = mode_q;
    hex_count_d  = hex_count_q;
    code_value_d = code_value_q;
    n_res        = 2'd0;
    for (int i = 0; i < MaxResults; i++) begin
      res[i] = '{kind: KIND_DATA, data: 8'h00, err: ERR_MISSING_QUOTE, last: 1'b0};
    end

    case (mode_q)
      MODE_IDLE: begin
        if (at_end_i) begin
          res[0].kind = KIND_ERR;
          res[0].err  = ERR_MISSING_QUOTE;
          n_res       = 2'd1;
        end else if (in_byte_i inside {ChSpace, ChTab, ChCr, ChLf}) begin
          n_res = 2'd0;
        end else if (in_byte_i == ChQuote) begin
          mode_d = MODE_STR;
        end else begin
          res[0].kind = KIND_ERR;
          res[0].err  = ERR_MISSING_QUOTE;
          n_res       = 2'd1;
        end
      end
      MODE_STR: begin
        if (at_end_i) begin
          res[0].kind = KIND_ERR;
          res[0].err  = ERR_UNTERM_STRING;
          n_res       = 2'd1;
        end else if (in_byte_i == ChQuote) begin
          mode_d      = MODE_IDLE;
          res[0].kind = KIND_END;
          n_res       = 2'd1;
        end else if (in_byte_i == ChBackslash) begin
          mode_d = MODE_ESC;
        end else begin
          res[0].data = in_byte_i;
          n_res       = 2'd1;
        end
      end
      MODE_ESC: begin
        if (at_end_i) begin
          res[0].kind = KIND_ERR;
          res[0].err  = ERR_UNTERM_ESCAPE;
          n_res       = 2'd1;
        end else begin
          mode_d = MODE_STR;
          n_res  = 2'd1;
          case (in_byte_i)
            ChQuote, ChBackslash, ChSlash: res[0].data = in_byte_i;
            ChLowerB: res[0].data = 8'h08;
            ChLowerF: res[0].data = 8'h0C;
            ChLowerN: res[0].data = 8'h0A;
            ChLowerR: res[0].data = 8'h0D;
            ChLowerT: res[0].data = 8'h09;
            ChLowerU: begin
              mode_d       = MODE_HEX;
              hex_count_d  = 2'd0;
              code_value_d = 16'h0000;
              n_res        = 2'd0;
            end
            default: begin
              res[0].kind = KIND_ERR;
              res[0].err  = ERR_UNSUPPORTED;
            end
          endcase
        end
      end
      MODE_HEX: begin
        if (at_end_i || hex_d[4]) begin
          res[0].kind = KIND_ERR;
          res[0].err  = ERR_BAD_UNICODE;
          n_res       = 2'd1;
        end else if (hex_count_q == 2'd3) begin
          mode_d       = MODE_STR;
          hex_count_d  = 2'd0;
          code_value_d = 16'h0000;
          if (code_nxt[15:7] == '0) begin
            res[0].data = {1'b0, code_nxt[6:0]};
            n_res       = 2'd1;
          end else if (code_nxt[15:11] == '0) begin
            res[0].data = {3'b110, code_nxt[10:6]};
            res[1].data = {2'b10, code_nxt[5:0]};
            n_res       = 2'd2;
          end else begin
            res[0].data = {4'b1110, code_nxt[15:12]};
            res[1].data = {2'b10, code_nxt[11:6]};
            res[2].data = {2'b10, code_nxt[5:0]};
            n_res       = 2'd3;
          end
        end else begin
          code_value_d = code_nxt;
          hex_count_d  = hex_count_q + 2'd1;
        end
      end
      default: mode_d = MODE_IDLE;
    endcase

    // Every error drops the decoder back to idle with the escape state cleared.
    if (res[0].kind == KIND_ERR) begin
      mode_d       = MODE_IDLE;
      hex_count_d  = 2'd0;
      code_value_d = 16'h0000;
    end

    for (int i = 0; i < MaxResults; i++) begin
      res[i].last = (n_res == 2'(i + 1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      hex_count_q  <= 2'd0;
      code_value_q <= 16'h0000;
    end else if (in_acc) begin
      mode_q       <= mode_d;
      hex_count_q  <= hex_count_d;
      code_value_q <= code_value_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(n_res);
      end
      if (out_acc) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + (in_acc ? QCntW'(n_res) : QCntW'(0)) - QCntW'(out_acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < MaxResults; i++) begin
        if (2'(i) < n_res) begin
          queue_q[wr_ptr_q + QPtrW'(i)] <= res[i];
        end
      end
    end
  end

  assign result_kind_o = queue_q[rd_ptr_q].kind;
  assign out_byte_o    = queue_q[rd_ptr_q].data;
  assign error_code_o  = queue_q[rd_ptr_q].err;
  assign last_o        = queue_q[rd_ptr_q].last;

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("output queue count exceeds its depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ({1'b0, cnt_q} + {{(QCntW-1){1'b0}}, n_res}) <= (QCntW + 1)'(QDepth))
    else $error("accepted transaction would overflow the output queue");

  a_err_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && n_res != 2'd0 && res[0].kind == KIND_ERR) |=> mode_q == MODE_IDLE)
    else $error("decoder not idle after an error result");

  a_hex_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != MODE_HEX |-> (hex_count_q == 2'd0 && code_value_q == 16'h0000))
    else $error("hex digit state left over outside a unicode escape");

endmodule

`default_nettype wire

// ===== tb/jsu_result_checker.sv =====
// Result checker for the JSON string unescaper: decodes every accepted text byte
// on its own, queues the results it expects and compares each accepted result.
// Depends on jsu_pkg.
`timescale 1ns / 1ps

module jsu_result_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] in_byte_i,
  input  logic       at_end_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [1:0] result_kind_i,
  input  logic [7:0] out_byte_i,
  input  logic [2:0] error_code_i,
  input  logic       last_i,
  output int         fail_count_o,
  output int         pending_o
);
  import jsu_pkg::*;

  mode_e       dec_mode;
  logic [1:0]  hex_seen;
  logic [15:0] unit_acc;
  result_t     pending_results[$];
  result_t     staged[$];
  result_t     got;
  result_t     want;
  int          mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic result_t mk_result(input kind_e k, input logic [7:0] d, input err_e e);
    result_t r;
    r.kind = k;
    r.data = d;
    r.err  = e;
    r.last = 1'b0;
    return r;
  endfunction

  // Appends one result to those caused by the current text byte.
  task automatic stage_result(input result_t r);
    staged.insert(staged.size(), r);
  endtask

  // Works out the results of one text byte (or end of text) and queues them.
  task automatic decode_text_byte(input logic [7:0] c, input logic eot);
    logic [4:0]  nib;
    logic [15:0] cp;
    logic        fault;
    err_e        code;
    staged.delete();
    fault = 1'b0;
    code  = ERR_MISSING_QUOTE;
    case (dec_mode)
      MODE_IDLE: begin
        if (eot) begin
          fault = 1'b1;
        end else if (c == ChQuote) begin
          dec_mode = MODE_STR;
        end else if (c != ChSpace && c != ChTab && c != ChCr && c != ChLf) begin
          fault = 1'b1;
        end
      end
      MODE_STR: begin
        if (eot) begin
          fault = 1'b1;
          code  = ERR_UNTERM_STRING;
        end else if (c == ChQuote) begin
          dec_mode = MODE_IDLE;
          stage_result(mk_result(KIND_END, 8'h00, ERR_MISSING_QUOTE));
        end else if (c == ChBackslash) begin
          dec_mode = MODE_ESC;
        end else begin
          stage_result(mk_result(KIND_DATA, c, ERR_MISSING_QUOTE));
        end
      end
      MODE_ESC: begin
        if (eot) begin
          fault = 1'b1;
          code  = ERR_UNTERM_ESCAPE;
        end else begin
          dec_mode = MODE_STR;
          case (c)
            ChQuote, ChBackslash, ChSlash:
              stage_result(mk_result(KIND_DATA, c, ERR_MISSING_QUOTE));
            ChLowerB: stage_result(mk_result(KIND_DATA, 8'h08, ERR_MISSING_QUOTE));
            ChLowerF: stage_result(mk_result(KIND_DATA, 8'h0C, ERR_MISSING_QUOTE));
            ChLowerN: stage_result(mk_result(KIND_DATA, 8'h0A, ERR_MISSING_QUOTE));
            ChLowerR: stage_result(mk_result(KIND_DATA, 8'h0D, ERR_MISSING_QUOTE));
            ChLowerT: stage_result(mk_result(KIND_DATA, 8'h09, ERR_MISSING_QUOTE));
            ChLowerU: begin
              dec_mode = MODE_HEX;
              hex_seen = 2'd0;
              unit_acc = 16'h0000;
            end
            default: begin
              fault = 1'b1;
              code  = ERR_UNSUPPORTED;
            end
          endcase
        end
      end
      default: begin
        nib = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
          nib = 5'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
          nib = 5'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h46) begin
          nib = 5'(c - 8'h41 + 8'd10);
        end
        if (eot || nib[4]) begin
          fault = 1'b1;
          code  = ERR_BAD_UNICODE;
        end else begin
          unit_acc = {unit_acc[11:0], nib[3:0]};
          if (hex_seen == 2'd3) begin
            cp       = unit_acc;
            dec_mode = MODE_STR;
            hex_seen = 2'd0;
            unit_acc = 16'h0000;
            if (cp <= 16'h007F) begin
              stage_result(mk_result(KIND_DATA, cp[7:0], ERR_MISSING_QUOTE));
            end else if (cp <= 16'h07FF) begin
              stage_result(mk_result(KIND_DATA, {3'b110, cp[10:6]}, ERR_MISSING_QUOTE));
              stage_result(mk_result(KIND_DATA, {2'b10, cp[5:0]}, ERR_MISSING_QUOTE));
            end else begin
              stage_result(mk_result(KIND_DATA, {4'b1110, cp[15:12]}, ERR_MISSING_QUOTE));
              stage_result(mk_result(KIND_DATA, {2'b10, cp[11:6]}, ERR_MISSING_QUOTE));
              stage_result(mk_result(KIND_DATA, {2'b10, cp[5:0]}, ERR_MISSING_QUOTE));
            end
          end else begin
            hex_seen = hex_seen + 2'd1;
          end
        end
      end
    endcase
    // Every error drops back to idle with the code unit cleared.
    if (fault) begin
      dec_mode = MODE_IDLE;
      hex_seen = 2'd0;
      unit_acc = 16'h0000;
      stage_result(mk_result(KIND_ERR, 8'h00, code));
    end
    if (staged.size() > 0) begin
      staged[staged.size() - 1].last = 1'b1;
    end
    foreach (staged[i]) begin
      pending_results.insert(pending_results.size(), staged[i]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_mode = MODE_IDLE;
      hex_seen = 2'd0;
      unit_acc = 16'h0000;
      pending_results.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got.kind = kind_e'(result_kind_i);
        got.data = out_byte_i;
        got.err  = err_e'(error_code_i);
        got.last = last_i;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result: kind %0d byte %02h err %0d last %0b",
                                    got.kind, got.data, got.err, got.last));
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            report_mismatch($sformatf(
              "result kind %0d byte %02h err %0d last %0b, wanted %0d %02h %0d %0b",
              got.kind, got.data, got.err, got.last,
              want.kind, want.data, want.err, want.last));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        decode_text_byte(in_byte_i, at_end_i);
      end
      pending_o <= pending_results.size();
    end
  end

endmodule

// ===== tb/json_string_unescape_tb.sv =====
// Testbench top for the JSON string unescaper: drives directed and random text,
// varies input idling and output back-pressure and gives the verdict.
// Depends on jsu_pkg, json_string_unescape and jsu_result_checker.
`timescale 1ns / 1ps

module json_string_unescape_tb;
  import jsu_pkg::*;

  localparam int HoldCycles = 80;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] in_byte_i;
  logic       at_end_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] result_kind_o;
  logic [7:0] out_byte_o;
  logic [2:0] error_code_o;
  logic       last_o;
  int         fail_count;
  int         pending;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_asked  = 0;
  int hold_served = 0;
  int sent_items  = 0;

  always #2 clk_i = ~clk_i;

  json_string_unescape i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .at_end_i     (at_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_kind_o(result_kind_o),
    .out_byte_o   (out_byte_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

  jsu_result_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .at_end_i     (at_end_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_kind_i(result_kind_o),
    .out_byte_i   (out_byte_o),
    .error_code_i (error_code_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Offers one text byte and returns at the edge where the transaction completes.
  task automatic offer_byte(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    at_end_i   <= eot;
    do @(posedge clk_i); while (in_stall_o);
    sent_items++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return 8'h30 + n;
    return (upper ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  task automatic send_good_string();
    int          parts;
    logic [15:0] cu;
    logic [7:0]  b;
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: offer_byte(ChSpace, 1'b0);
        1: offer_byte(ChTab, 1'b0);
        2: offer_byte(ChCr, 1'b0);
        default: offer_byte(ChLf, 1'b0);
      endcase
    end
    offer_byte(ChQuote, 1'b0);
    parts = $urandom_range(0, 6);
    repeat (parts) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          do b = 8'($urandom_range(255)); while (b == ChQuote || b == ChBackslash);
          offer_byte(b, 1'b0);
        end
        4, 5, 6: begin
          offer_byte(ChBackslash, 1'b0);
          case ($urandom_range(7))
            0: offer_byte(ChQuote, 1'b0);
            1: offer_byte(ChBackslash, 1'b0);
            2: offer_byte(ChSlash, 1'b0);
            3: offer_byte(ChLowerB, 1'b0);
            4: offer_byte(ChLowerF, 1'b0);
            5: offer_byte(ChLowerN, 1'b0);
            6: offer_byte(ChLowerR, 1'b0);
            default: offer_byte(ChLowerT, 1'b0);
          endcase
        end
        default: begin
          offer_byte(ChBackslash, 1'b0);
          offer_byte(ChLowerU, 1'b0);
          // Spread the code units over the one, two and three byte encodings,
          // with their boundaries now and then.
          case ($urandom_range(9))
            0: begin
              case ($urandom_range(5))
                0: cu = 16'h0000;
                1: cu = 16'h007F;
                2: cu = 16'h0080;
                3: cu = 16'h07FF;
                4: cu = 16'h0800;
                default: cu = 16'hFFFF;
              endcase
            end
            1, 2, 3: cu = 16'($urandom_range(16'h007F));
            4, 5, 6: cu = 16'($urandom_range(16'h0080, 16'h07FF));
            default: cu = 16'($urandom_range(16'h0800, 16'hFFFF));
          endcase
          for (int i = 3; i >= 0; i--) begin
            offer_byte(hex_char(cu[4*i +: 4], 1'($urandom_range(1))), 1'b0);
          end
        end
      endcase
    end
    offer_byte(ChQuote, 1'b0);
  endtask

  task automatic send_broken();
    int sel;
    sel = $urandom_range(6);
    case (sel)
      0: offer_byte(8'($urandom_range(255)), 1'b0);
      1: offer_byte(8'($urandom_range(255)), 1'b1);
      2: begin
        offer_byte(ChQuote, 1'b0);
        repeat ($urandom_range(0, 3)) offer_byte(8'($urandom_range(255)), 1'b0);
        offer_byte(8'($urandom_range(255)), 1'b1);
      end
      3: begin
        offer_byte(ChQuote, 1'b0);
        offer_byte(ChBackslash, 1'b0);
        offer_byte(8'($urandom_range(255)), 1'b1);
      end
      4: begin
        offer_byte(ChQuote, 1'b0);
        offer_byte(ChBackslash, 1'b0);
        offer_byte(8'($urandom_range(255)), 1'b0);
      end
      default: begin
        offer_byte(ChQuote, 1'b0);
        offer_byte(ChBackslash, 1'b0);
        offer_byte(ChLowerU, 1'b0);
        repeat ($urandom_range(0, 3)) begin
          offer_byte(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b0);
        end
        // Either the text runs out among the digits or a stray byte arrives.
        offer_byte(8'($urandom_range(255)), sel == 5);
      end
    endcase
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    int goal;
    idle_pct  = idle;
    stall_pct = stall;
    goal      = sent_items + count;
    while (sent_items < goal) begin
      if ($urandom_range(99) < 80) begin
        send_good_string();
      end else begin
        send_broken();
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asked != hold_served) begin
        hold_served++;
        out_stall_i <= 1'b1;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    #500_000;
    $display("FAIL json_string_unescape");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_byte_i  = 8'h00;
    at_end_i   = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // End of text while idle, skipped whitespace and a stray byte while idle.
    offer_byte(8'hA5, 1'b1);
    offer_byte(ChSpace, 1'b0);
    offer_byte(ChTab, 1'b0);
    offer_byte(ChCr, 1'b0);
    offer_byte(ChLf, 1'b0);
    offer_byte(8'h78, 1'b0);
    // Extreme plain bytes, then an unknown escape letter.
    offer_byte(ChQuote, 1'b0);
    offer_byte(8'h00, 1'b0);
    offer_byte(8'hFF, 1'b0);
    offer_byte(ChBackslash, 1'b0);
    offer_byte(8'h71, 1'b0);
    // Text ends right after a backslash.
    offer_byte(ChQuote, 1'b0);
    offer_byte(ChBackslash, 1'b0);
    offer_byte(8'h5A, 1'b1);
    // Largest code unit as three bytes, then text ends inside the string.
    offer_byte(ChQuote, 1'b0);
    offer_byte(ChBackslash, 1'b0);
    offer_byte(ChLowerU, 1'b0);
    repeat (4) offer_byte(8'h46, 1'b0);
    offer_byte(8'h00, 1'b1);
    // A byte that is no hex digit inside a unicode escape.
    offer_byte(ChQuote, 1'b0);
    offer_byte(ChBackslash, 1'b0);
    offer_byte(ChLowerU, 1'b0);
    offer_byte(8'h37, 1'b0);
    offer_byte(8'h67, 1'b0);

    run_phase(0, 0, 85);
    run_phase(52, 0, 85);
    run_phase(0, 52, 85);

    // Hold the output off while the sender keeps going, so the queue fills.
    idle_pct  = 0;
    stall_pct = 0;
    hold_asked++;
    while (sent_items < 345) send_good_string();

    run_phase(16, 16, 85);

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS json_string_unescape");
    end else begin
      $display("FAIL json_string_unescape");
    end
    $finish;
  end

endmodule

// ===== json_string_unescape.f =====
rtl/jsu_pkg.sv
rtl/json_string_unescape.sv
tb/jsu_result_checker.sv
tb/json_string_unescape_tb.sv
